/* src/cle_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Console line editor package
// Shared sizes, character codes, state and result encodings, and the
// set-1 scancode decode tables.
// ----------------------------------------------------------------------------
package cle_pkg;

  // Line buffer size and derived widths.
  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > 6) ? CNT_W : 6;

  // Field widths fixed by the interface.
  localparam int CODE_W = 8;
  localparam int KIND_W = 3;
  localparam int POS_W  = 6;
  localparam int MAXC_W = 6;

  // Configuration register indexes.
  localparam logic REG_INPUT_MODE = 1'b0;
  localparam logic REG_MAX_CHARS  = 1'b1;

  // Reset value of the character limit.
  localparam logic [MAXC_W-1:0] MAX_CHARS_RST = 6'd32;

  // Control characters.
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_ESC   = 8'd27;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7f;

  // Set-1 scancodes.
  localparam logic [7:0] SC_LEFT_MAKE   = 8'd42;
  localparam logic [7:0] SC_RIGHT_MAKE  = 8'd54;
  localparam logic [7:0] SC_LEFT_BREAK  = 8'd42 | 8'h80;
  localparam logic [7:0] SC_RIGHT_BREAK = 8'd54 | 8'h80;
  localparam logic [7:0] SC_LIMIT       = 8'd59;

  // Result kinds.
  typedef enum logic [KIND_W-1:0] {
    K_ECHO  = 3'd0,
    K_ERASE = 3'd1,
    K_CLEAR = 3'd2,
    K_LINE  = 3'd3,
    K_EMPTY = 3'd4
  } kind_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_PROC,
    S_RD_ERASE,
    S_ERASE,
    S_RD_LINE,
    S_LINE
  } state_e;

  typedef logic [7:0] map_t [64];

  // Unshifted decode table; entries past the last key are spaces.
  localparam map_t PLAIN_MAP = '{
    8'h20, 8'h1b, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2d, 8'h3d, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6f, 8'h70, 8'h5b, 8'h5d, 8'h0d, 8'h20,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h3b,
    8'h27, 8'h7e, 8'h20, 8'h5c, 8'h7a, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6e,
    8'h6d, 8'h2c, 8'h2e, 8'h2f, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20,
    8'h20, 8'h20, 8'h20, 8'h20
  };

  // Shifted decode table.
  localparam map_t UPPER_MAP = '{
    8'h20, 8'h1b, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e, 8'h26, 8'h2a,
    8'h28, 8'h29, 8'h5f, 8'h2b, 8'h20, 8'h20, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4f, 8'h50, 8'h7b, 8'h7d, 8'h0d, 8'h20,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3a,
    8'h22, 8'h7e, 8'h20, 8'h7c, 8'h5a, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4e,
    8'h4d, 8'h3c, 8'h3e, 8'h3f, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20,
    8'h20, 8'h20, 8'h20, 8'h20
  };

endpackage : cle_pkg
`default_nettype wire

/* src/console_line_editor.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Console line editor
// Edits a line of characters from set-1 scancodes or ASCII bytes, held in a
// small RAM, and emits echo, erase, clear and finished-line results.
// ----------------------------------------------------------------------------
//  Channel   Signals                                       Direction
//  -------   -------------------------------------------   ---------
//  config    cfg_we_i, cfg_idx_i, cfg_data_i                in
//  input     in_valid_i / in_stall_o, code_i                in
//  output    out_valid_o / out_stall_i, kind_o, char_out_o,  out
//            position_o, last_o
//
// An input beat is accepted, then decoded and acted on; an erase also
// reads the erased character from the line RAM before it is emitted.
// End of line emits each stored character in turn: each one is a RAM
// read followed by a load of the output register.
// Reset clears the fill count, shift state and configuration; the line RAM
// is not cleared, as only written entries are ever read.
// A stall on the output holds the sequencer until the output register frees.
// ----------------------------------------------------------------------------
module console_line_editor (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Configuration writes
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_idx_i,
  input  wire logic [cle_pkg::MAXC_W-1:0]  cfg_data_i,
  // Input bytes
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [cle_pkg::CODE_W-1:0]  code_i,
  // Results
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [cle_pkg::KIND_W-1:0]  kind_o,
  output logic      [7:0]                  char_out_o,
  output logic      [cle_pkg::POS_W-1:0]   position_o,
  output logic                             last_o
);

  import cle_pkg::*;

  // Configuration registers.
  logic              mode_q;
  logic [MAXC_W-1:0] max_q;

  // Control state.
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic              shift_q, shift_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [CODE_W-1:0] code_q;

  // Output register.
  logic              out_valid_q;
  logic              ld;
  kind_e             ld_kind;
  logic [7:0]        ld_char;
  logic [POS_W-1:0]  ld_pos;
  logic              ld_last;
  kind_e             kind_q;
  logic [7:0]        char_q;
  logic [POS_W-1:0]  pos_q;
  logic              last_q;
  logic              out_free;

  // Line RAM signals.
  logic              ram_we;
  logic [7:0]        ram_rdata;

  // Decode signals.
  logic              sc_make;
  logic              sc_break;
  logic              sc_ignore;
  logic [7:0]        ch;
  logic              end_line;
  logic              printable;
  logic              has_room;
  logic              idx_last;

  // Configuration write port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      max_q  <= MAX_CHARS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_INPUT_MODE: mode_q <= cfg_data_i[0];
        REG_MAX_CHARS:  max_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The line store.
  cle_ram #(
    .WIDTH (8),
    .DEPTH (CAPACITY)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[IDX_W-1:0]),
    .wdata_i (ch),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // Decode the held byte.
  always_comb begin
    sc_make   = (code_q == SC_LEFT_MAKE) || (code_q == SC_RIGHT_MAKE);
    sc_break  = (code_q == SC_LEFT_BREAK) || (code_q == SC_RIGHT_BREAK);
    sc_ignore = code_q[7] || (code_q >= SC_LIMIT);
    if (mode_q) begin
      ch       = code_q;
      end_line = (code_q == CH_CR) || (code_q == CH_LF);
      printable = (code_q >= CH_SPACE) && (code_q < CH_DEL);
    end else begin
      ch       = shift_q ? UPPER_MAP[code_q[5:0]] : PLAIN_MAP[code_q[5:0]];
      end_line = (ch == CH_CR);
      printable = 1'b1;
    end
    has_room = (CMP_W'(fill_q) < CMP_W'(max_q)) && (fill_q < CNT_W'(CAPACITY));
    idx_last = ((CNT_W'(idx_q) + CNT_W'(1)) == fill_q);
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer state and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      shift_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      shift_q <= shift_d;
      idx_q   <= idx_d;
    end
  end

  // Accepted byte.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      code_q <= code_i;
    end
  end

  // Next state, RAM write and output load.
  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    shift_d = shift_q;
    idx_d   = idx_q;
    ram_we  = 1'b0;
    ld      = 1'b0;
    ld_kind = K_ECHO;
    ld_char = '0;
    ld_pos  = '0;
    ld_last = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_PROC;
        end
      end
      S_PROC: begin
        if (!mode_q && sc_make) begin
          shift_d = 1'b1;
          state_d = S_IDLE;
        end else if (!mode_q && sc_break) begin
          shift_d = 1'b0;
          state_d = S_IDLE;
        end else if (!mode_q && sc_ignore) begin
          state_d = S_IDLE;
        end else if (end_line) begin
          if (fill_q == '0) begin
            // Empty line: a single end marker.
            if (out_free) begin
              ld      = 1'b1;
              ld_kind = K_EMPTY;
              shift_d = 1'b0;
              state_d = S_IDLE;
            end
          end else begin
            shift_d = 1'b0;
            idx_d   = '0;
            state_d = S_RD_LINE;
          end
        end else if (ch == CH_BS) begin
          if (fill_q == '0) begin
            state_d = S_IDLE;
          end else begin
            fill_d  = fill_q - CNT_W'(1);
            idx_d   = IDX_W'(fill_q - CNT_W'(1));
            state_d = S_RD_ERASE;
          end
        end else if (ch == CH_ESC) begin
          if (out_free) begin
            ld      = 1'b1;
            ld_kind = K_CLEAR;
            fill_d  = '0;
            state_d = S_IDLE;
          end
        end else if (!printable || !has_room) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          // Append and echo.
          ram_we  = 1'b1;
          ld      = 1'b1;
          ld_kind = K_ECHO;
          ld_char = ch;
          ld_pos  = POS_W'(fill_q);
          fill_d  = fill_q + CNT_W'(1);
          state_d = S_IDLE;
        end
      end
      S_RD_ERASE: begin
        state_d = S_ERASE;
      end
      S_ERASE: begin
        if (out_free) begin
          ld      = 1'b1;
          ld_kind = K_ERASE;
          ld_char = ram_rdata;
          ld_pos  = POS_W'(idx_q);
          state_d = S_IDLE;
        end
      end
      S_RD_LINE: begin
        state_d = S_LINE;
      end
      S_LINE: begin
        // Emit one stored character per read.
        if (out_free) begin
          ld      = 1'b1;
          ld_kind = K_LINE;
          ld_char = ram_rdata;
          ld_pos  = POS_W'(idx_q);
          ld_last = idx_last;
          if (idx_last) begin
            fill_d  = '0;
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = S_RD_LINE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (ld) begin
      kind_q <= ld_kind;
      char_q <= ld_char;
      pos_q  <= ld_pos;
      last_q <= ld_last;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign char_out_o  = char_q;
  assign position_o  = pos_q;
  assign last_o      = last_q;

endmodule : console_line_editor
`default_nettype wire

/* src/cle_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule : cle_ram
`default_nettype wire

/* src/cle_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Console line editor port checker
// Watches the top-level ports for handshake and result-format slips.
// ----------------------------------------------------------------------------
module cle_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [cle_pkg::KIND_W-1:0]  kind_o,
  input wire logic [7:0]                  char_out_o,
  input wire logic [cle_pkg::POS_W-1:0]   position_o,
  input wire logic                        last_o
);

  import cle_pkg::*;

  // A stalled result beat stays and holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
      $stable(char_out_o) && $stable(position_o) && $stable(last_o))
    else $error("stalled result beat changed");

  // The block works on one byte at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted on back-to-back cycles");

  // Only defined result kinds appear.
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> kind_o <= 3'(K_EMPTY))
    else $error("undefined result kind");

  // Clear and empty-line results carry no character and close their input.
  a_marker_fmt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == 3'(K_CLEAR) || kind_o == 3'(K_EMPTY)) |->
      char_out_o == 8'd0 && position_o == '0 && last_o)
    else $error("malformed clear or empty-line result");

  // Echo and erase are single results.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == 3'(K_ECHO) || kind_o == 3'(K_ERASE)) |-> last_o)
    else $error("echo or erase result without last");

endmodule : cle_checker

bind console_line_editor cle_checker u_cle_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .kind_o      (kind_o),
  .char_out_o  (char_out_o),
  .position_o  (position_o),
  .last_o      (last_o)
);
`default_nettype wire

/* tb/console_line_editor_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Console line editor testbench
// Feeds scancode and ASCII bytes to the line editor in bursts while the
// result side stalls on its own pattern. A local model of the line buffer,
// shift state and configuration predicts every result, and the monitor
// compares each result beat field by field in order.
// ----------------------------------------------------------------------------
module console_line_editor_tb;
  import cle_pkg::*;

  localparam int LIMIT_NS  = 1_000_000;
  localparam int IDLE_GAP  = 8;
  localparam int DRAIN_GAP = 20;

  // Set-1 scancodes of the editing keys.
  localparam logic [7:0] SC_ESC_KEY   = 8'd1;
  localparam logic [7:0] SC_BKSP_KEY  = 8'd14;
  localparam logic [7:0] SC_TAB_KEY   = 8'd15;
  localparam logic [7:0] SC_ENTER_KEY = 8'd28;

  typedef logic [7:0] keymap_t [59];

  // Unshifted key characters.
  localparam keymap_t KEY_LOWER = '{
    8'h20, 8'h1b, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2d, 8'h3d, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6f, 8'h70, 8'h5b, 8'h5d, 8'h0d, 8'h20,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h3b,
    8'h27, 8'h7e, 8'h20, 8'h5c, 8'h7a, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6e,
    8'h6d, 8'h2c, 8'h2e, 8'h2f, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20
  };

  // Shifted key characters; shifted backspace and tab give a space.
  localparam keymap_t KEY_UPPER = '{
    8'h20, 8'h1b, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e, 8'h26, 8'h2a,
    8'h28, 8'h29, 8'h5f, 8'h2b, 8'h20, 8'h20, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4f, 8'h50, 8'h7b, 8'h7d, 8'h0d, 8'h20,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3a,
    8'h22, 8'h7e, 8'h20, 8'h7c, 8'h5a, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4e,
    8'h4d, 8'h3c, 8'h3e, 8'h3f, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20
  };

  typedef struct {
    kind_e      kind;
    logic [7:0] ch;
    logic [5:0] pos;
    logic       last;
  } line_result_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic                cfg_idx_i   = REG_INPUT_MODE;
  logic [MAXC_W-1:0]   cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic [CODE_W-1:0]   code_i      = '0;
  logic                out_stall_i = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic [KIND_W-1:0]   kind_o;
  logic [7:0]          char_out_o;
  logic [POS_W-1:0]    position_o;
  logic                last_o;

  console_line_editor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .code_i      (code_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .char_out_o  (char_out_o),
    .position_o  (position_o),
    .last_o      (last_o)
  );

  // Bytes waiting to be sent and results the editor still owes.
  logic [7:0]   key_queue [$];
  line_result_t pending_results [$];

  // Local copy of the editor state and its registers.
  logic [7:0]        store_q [CAPACITY];
  int                fill_q  = 0;
  bit                shift_q = 1'b0;
  bit                mode_q  = 1'b0;
  logic [MAXC_W-1:0] max_q   = MAX_CHARS_RST;

  int mismatches   = 0;
  int bytes_taken  = 0;
  int results_seen = 0;
  int lines_done   = 0;

  // Sender burst and receiver stall bookkeeping.
  int burst_left  = 0;
  int gap_left    = 0;
  int stall_left  = 0;
  int stall_style = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] result %0d: %s got %0h want %0h", $realtime, results_seen, what,
             got, want);
    mismatches++;
  endtask

  task automatic queue_result(input kind_e kind, input logic [7:0] ch, input int pos,
                              input bit last);
    line_result_t r;
    r.kind = kind;
    r.ch   = ch;
    r.pos  = pos[5:0];
    r.last = last;
    pending_results.push_back(r);
  endtask

  // Decode one accepted byte, update the local editor state and queue the
  // results it causes.
  task automatic edit_line(input logic [7:0] code);
    logic [7:0] ch;
    bit         end_line;
    bit         printable_only;
    bit         skip;
    int         n;
    ch             = code;
    end_line       = 1'b0;
    printable_only = 1'b0;
    skip           = 1'b0;
    if (mode_q) begin
      end_line       = (code == CH_CR) || (code == CH_LF);
      printable_only = 1'b1;
    end else if (code == SC_LEFT_MAKE || code == SC_RIGHT_MAKE) begin
      shift_q = 1'b1;
      skip    = 1'b1;
    end else if (code == SC_LEFT_BREAK || code == SC_RIGHT_BREAK) begin
      shift_q = 1'b0;
      skip    = 1'b1;
    end else if (code[7] || code >= SC_LIMIT) begin
      skip = 1'b1;
    end else begin
      ch       = shift_q ? KEY_UPPER[code] : KEY_LOWER[code];
      end_line = (ch == CH_CR);
    end

    if (!skip) begin
      if (end_line) begin
        n       = fill_q;
        fill_q  = 0;
        shift_q = 1'b0;
        lines_done++;
        if (n == 0) begin
          queue_result(K_EMPTY, 8'h00, 0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) queue_result(K_LINE, store_q[i], i, i == n - 1);
        end
      end else if (ch == CH_BS) begin
        if (fill_q > 0) begin
          fill_q--;
          queue_result(K_ERASE, store_q[fill_q], fill_q, 1'b1);
        end
      end else if (ch == CH_ESC) begin
        fill_q = 0;
        queue_result(K_CLEAR, 8'h00, 0, 1'b1);
      end else if (!(printable_only && (ch < CH_SPACE || ch >= CH_DEL)) &&
                   fill_q < int'(max_q) && fill_q < CAPACITY) begin
        store_q[fill_q] = ch;
        queue_result(K_ECHO, ch, fill_q, 1'b1);
        fill_q++;
      end
    end
  endtask

  // Sender: bursts of beats separated by random gaps; a stalled beat holds.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (key_queue.size() > 0) begin
        in_valid_i <= 1'b1;
        code_i     <= key_queue.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(12);
          gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: free-running, choppy and held stretches of stall.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(2);
      stall_left  = (stall_style == 2) ? $urandom_range(12, 1) : $urandom_range(50, 10);
    end
    stall_left--;
    case (stall_style)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(2) == 0);
      default: out_stall_i <= 1'b1;
    endcase
  end

  // Monitor: mirror register writes, check result beats, predict on input beats.
  always @(posedge clk_i) begin : monitor
    line_result_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_INPUT_MODE) mode_q = cfg_data_i[0];
        else max_q = cfg_data_i;
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, kind", int'(kind_o), 0);
        end else begin
          want = pending_results.pop_front();
          if (kind_o !== want.kind)
            report_mismatch("kind", int'(kind_o), int'(want.kind));
          if (char_out_o !== want.ch)
            report_mismatch("char_out", int'(char_out_o), int'(want.ch));
          if (position_o !== want.pos)
            report_mismatch("position", int'(position_o), int'(want.pos));
          if (last_o !== want.last)
            report_mismatch("last", int'(last_o), int'(want.last));
        end
        results_seen++;
      end
      if (in_valid_i && !in_stall_o) begin
        bytes_taken++;
        edit_line(code_i);
      end
    end
  end

  // Wait until every queued byte is taken and every result has come back,
  // then let an ignored byte finish inside the editor.
  task automatic wait_idle(input int extra);
    @(negedge clk_i);
    while (key_queue.size() != 0 || in_valid_i || pending_results.size() != 0)
      @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [MAXC_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic set_mode(input bit ascii, input int chars);
    wait_idle(IDLE_GAP);
    write_reg(REG_INPUT_MODE, {{(MAXC_W-1){1'b0}}, ascii});
    write_reg(REG_MAX_CHARS, chars[MAXC_W-1:0]);
  endtask

  // One random byte: mostly characters to append, then editing keys,
  // shift events and raw noise over the whole byte range.
  function automatic logic [7:0] pick_code(input bit ascii, input int append_pct);
    logic [7:0] c;
    int         k;
    if ($urandom_range(99) < append_pct) begin
      if (ascii) begin
        c = 8'($urandom_range(8'h7e, 8'h20));
      end else begin
        c = 8'($urandom_range(58));
        while (c == SC_ESC_KEY || c == SC_BKSP_KEY || c == SC_ENTER_KEY ||
               c == SC_LEFT_MAKE || c == SC_RIGHT_MAKE)
          c = 8'($urandom_range(58));
      end
    end else begin
      k = $urandom_range(99);
      if (!ascii && k < 20) begin
        case ($urandom_range(3))
          0:       c = SC_LEFT_MAKE;
          1:       c = SC_RIGHT_MAKE;
          2:       c = SC_LEFT_BREAK;
          default: c = SC_RIGHT_BREAK;
        endcase
      end else if (k < 35) begin
        c = ascii ? CH_BS : SC_BKSP_KEY;
      end else if (k < 45) begin
        c = ascii ? CH_ESC : SC_ESC_KEY;
      end else if (k < 70) begin
        c = ascii ? (($urandom_range(1) == 0) ? CH_CR : CH_LF) : SC_ENTER_KEY;
      end else begin
        c = 8'($urandom_range(255));
      end
    end
    return c;
  endfunction

  task automatic random_phase(input bit ascii, input int chars, input int count,
                              input int append_pct);
    set_mode(ascii, chars);
    repeat (count) key_queue.push_back(pick_code(ascii, append_pct));
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Scancodes at reset settings: empty-line edits, shift handling,
    // ignored codes and a short finished line.
    key_queue = '{SC_BKSP_KEY, SC_ESC_KEY, SC_ENTER_KEY, 8'd0, SC_TAB_KEY, 8'd16,
                  SC_LEFT_MAKE, 8'd16, SC_BKSP_KEY, SC_LEFT_BREAK, SC_RIGHT_MAKE,
                  8'd2, SC_RIGHT_BREAK, 8'd158, SC_LIMIT, 8'd255, 8'd58,
                  SC_BKSP_KEY, SC_ENTER_KEY};

    // ASCII with a two-character line: printable edges, a full line,
    // ignored bytes, erase, clear and both line endings.
    set_mode(1'b1, 2);
    key_queue = '{8'h20, 8'h7e, 8'h41, CH_DEL, 8'h00, CH_BS, CH_ESC, CH_LF, 8'h31,
                  CH_CR};

    // Fill the whole buffer past capacity, then finish the line.
    set_mode(1'b0, CAPACITY);
    repeat (36) key_queue.push_back(pick_code(1'b0, 100));
    key_queue.push_back(SC_ENTER_KEY);

    random_phase(1'b0, CAPACITY, 10, 70);
    random_phase(1'b1, 1, 20, 60);
    random_phase(1'b0, $urandom_range(31, 2), 35, 70);
    random_phase(1'b1, CAPACITY, 30, 75);
    random_phase(1'b0, 1, 12, 60);
    random_phase(1'b1, $urandom_range(CAPACITY, 1), 15, 70);

    wait_idle(DRAIN_GAP);
    $display("Sent %0d bytes in scancode and ASCII modes, checked %0d results", bytes_taken,
             results_seen);
    $display("over %0d finished lines with limits from 1 to %0d characters", lines_done,
             CAPACITY);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule

/* sim.f */
src/cle_pkg.sv
src/cle_ram.sv
src/console_line_editor.sv
src/cle_checker.sv
tb/console_line_editor_tb.sv
